/* hdl/series_sin_arctan_ln_unit_assert.svh */
// ---------------------------------------------------------------------------
// Series evaluation unit: assertion macros
// Shared property forms for the concurrent checks of the series unit.
// ---------------------------------------------------------------------------
`ifndef SERIES_SIN_ARCTAN_LN_UNIT_ASSERT_SVH
`define SERIES_SIN_ARCTAN_LN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SSAL_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SSAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ssal_pkg.sv */
// ---------------------------------------------------------------------------
// Series evaluation unit package
// Word types, command and status codes and fixed datapath constants.
// ---------------------------------------------------------------------------
package ssal_pkg;

    // Input word: command and fixed-point argument.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] arg_value;
    } t_in_word;

    // Result word: saturated sum, number of terms and status.
    typedef struct packed {
        logic signed [39:0] series_sum;
        logic [7:0]         terms_used;
        logic [1:0]         status;
    } t_out_word;

    localparam logic [1:0] CMD_SIN  = 2'd0;
    localparam logic [1:0] CMD_ATAN = 2'd1;
    localparam logic [1:0] CMD_LN   = 2'd2;

    localparam logic [1:0] ST_CONV   = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_DOMAIN = 2'd2;

    localparam logic [7:0] TERM_LIMIT_RESET = 8'd64;

    // Term magnitudes and powers are clamped to 2^61, so they need 62 bits.
    localparam int unsigned MAG_W = 62;
    localparam logic [MAG_W-1:0] SAT_MAG = {1'b1, {(MAG_W-1){1'b0}}};

    // Running sum: signed, magnitude up to 2^61.
    localparam int unsigned SUM_W = 63;

    // Divisor width: (2k)(2k+1) for k up to 256 stays below 2^19.
    localparam int unsigned DVS_W = 19;
    localparam logic [DVS_W-1:0] DVS_SIN_INIT  = 19'd6;
    localparam logic [DVS_W-1:0] DVS_ATAN_INIT = 19'd3;
    localparam logic [DVS_W-1:0] DVS_LN_INIT   = 19'd2;
    localparam logic [DVS_W-1:0] DVS_SIN_BIAS  = 19'd6;
    localparam logic [DVS_W-1:0] DVS_ATAN_STEP = 19'd2;
    localparam logic [DVS_W-1:0] DVS_LN_STEP   = 19'd1;

endpackage

/* hdl/series_sin_arctan_ln_unit.sv */
// ---------------------------------------------------------------------------
// Series evaluation unit
// Sine, arctangent and natural logarithm of a fixed-point argument by their
// power series, summed term by term on one shared multiplier and divider.
// ---------------------------------------------------------------------------
// Flow: an argument outside the domain goes straight to the output state;
//   else each term runs a check, multiply passes on the 31 x 32 multiplier
//   (two, or one for ln) and a division. Throughput: one word at a time.
// Reset: synchronous, active low; clears the sequencer, the output valid and
//   sets term_limit to 64.
// ---------------------------------------------------------------------------
module series_sin_arctan_ln_unit
    import ssal_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 29
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // Input channel.
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    // Result channel.
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    // Configuration: term_limit.
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    `include "series_sin_arctan_ln_unit_assert.svh"

    // The multiplier operand is |x| or |x-1|. The latter can reach 2^FRAC_BITS
    // when the fraction is wider than the argument's integer range allows.
    localparam int unsigned OPW    = (FRAC_BITS + 1 > 32) ? FRAC_BITS + 1 : 32;
    localparam int unsigned HALF_W = MAG_W / 2;
    localparam int unsigned PROD_W = MAG_W + OPW;
    localparam int unsigned MULP_W = HALF_W + OPW;

    localparam logic signed [63:0] ONE64   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] TWO64   = 64'sd2 <<< FRAC_BITS;
    localparam logic signed [63:0] SUM_MAX = 64'sd1 <<< (MAG_W - 1);
    localparam logic signed [63:0] SUM_MIN = -SUM_MAX;
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'sd1 <<< 39) - 64'sd1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(64'sd1 <<< 39));

    // One-hot sequencer. A term runs CHECK, then one or two multiply passes
    // (LO, HI, SAT each), then the divider, then back to CHECK.
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CHECK   = 7'b0000010,
        S_MUL_LO  = 7'b0000100,
        S_MUL_HI  = 7'b0001000,
        S_MUL_SAT = 7'b0010000,
        S_DIV     = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_div_start, n_div_start;
    logic [7:0] r_limit;

    // Datapath registers.
    logic [1:0]              r_cmd, n_cmd;
    logic [OPW-1:0]          r_mb, n_mb;       // |x| or |x-1|
    logic [MAG_W-1:0]        r_mop, n_mop;     // multiplicand of this pass
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [MAG_W-1:0]        r_pw, n_pw;       // running power, divider input
    logic [MAG_W-1:0]        r_mag, n_mag;     // magnitude of the next term
    logic                    r_neg, n_neg;     // sign of the next term
    logic                    r_uneg, n_uneg;   // x - 1 is negative
    logic                    r_pass, n_pass;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [7:0]              r_used, n_used;
    logic [1:0]              r_status, n_status;
    logic [DVS_W-1:0]        r_dvs, n_dvs;
    t_out_word               r_out_word, n_out_word;

    // Argument decode at acceptance.
    logic signed [63:0] arg_x, arg_u;
    logic [31:0]        arg_ax;
    logic [63:0]        arg_au;
    logic               arg_bad;

    // Shared multiplier, saturation and sum datapath.
    logic [HALF_W-1:0]       mul_a;
    logic [MULP_W-1:0]       mul_p;
    logic [PROD_W-1:0]       prod_sh;
    logic [MAG_W-1:0]        sat_res;
    logic signed [63:0]      sum_ext, mag_ext, sum_new;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [39:0]      sum_out;

    logic             div_done;
    logic [MAG_W-1:0] div_q;

    ssal_div #(
        .DVD_W (MAG_W),
        .DIV_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_pw),
        .i_divisor  (r_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // The argument is a 32-bit signed value; the magnitude of -2^31 still
    // fits an unsigned 32-bit word. Domain tests run on 64-bit values so
    // that any FRAC_BITS in range compares correctly.
    always_comb begin
        arg_x   = {{32{i_in_word.arg_value[31]}}, i_in_word.arg_value};
        arg_ax  = i_in_word.arg_value[31] ? (~i_in_word.arg_value + 32'd1)
                                          : i_in_word.arg_value;
        arg_u   = arg_x - ONE64;
        arg_au  = arg_u[63] ? 64'(-arg_u) : 64'(arg_u);
        arg_bad = (i_in_word.cmd != CMD_SIN && i_in_word.cmd != CMD_ATAN &&
                   i_in_word.cmd != CMD_LN) ||
                  (i_in_word.cmd == CMD_ATAN && {32'd0, arg_ax} > 64'(ONE64)) ||
                  (i_in_word.cmd == CMD_LN && (arg_x <= 64'sd0 || arg_x > TWO64));
    end

    // One 31 x OPW multiplier serves both halves of the 62-bit multiplicand.
    assign mul_a = (r_state == S_MUL_HI) ? r_mop[MAG_W-1:HALF_W] : r_mop[HALF_W-1:0];
    assign mul_p = mul_a * r_mb;

    // Scale back by the fraction width and clamp to 2^61.
    assign prod_sh = r_prod >> FRAC_BITS;
    assign sat_res = (prod_sh > PROD_W'(SAT_MAG)) ? SAT_MAG : prod_sh[MAG_W-1:0];

    // Add or subtract the current term, clamped to +/- 2^61.
    always_comb begin
        sum_ext = {r_sum[SUM_W-1], r_sum};
        mag_ext = {2'b00, r_mag};
        sum_new = r_neg ? (sum_ext - mag_ext) : (sum_ext + mag_ext);
        if (sum_new > SUM_MAX) begin
            sum_sat = SUM_W'(SUM_MAX);
        end else if (sum_new < SUM_MIN) begin
            sum_sat = SUM_W'(SUM_MIN);
        end else begin
            sum_sat = sum_new[SUM_W-1:0];
        end
    end

    // Final clamp to the 40-bit result range.
    always_comb begin
        if (r_sum > OUT_MAX) begin
            sum_out = OUT_MAX[39:0];
        end else if (r_sum < OUT_MIN) begin
            sum_out = OUT_MIN[39:0];
        end else begin
            sum_out = r_sum[39:0];
        end
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_div_start = 1'b0;
        n_cmd       = r_cmd;
        n_mb        = r_mb;
        n_mop       = r_mop;
        n_prod      = r_prod;
        n_pw        = r_pw;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_uneg      = r_uneg;
        n_pass      = r_pass;
        n_sum       = r_sum;
        n_used      = r_used;
        n_status    = r_status;
        n_dvs       = r_dvs;
        n_out_word  = r_out_word;

        // The output register frees as soon as the consumer takes the word.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd  = i_in_word.cmd;
                    n_sum  = '0;
                    n_used = '0;
                    n_uneg = arg_u[63];
                    if (arg_bad) begin
                        n_status = ST_DOMAIN;
                        n_state  = S_OUT;
                    end else begin
                        // The first term is the argument itself (or x - 1).
                        if (i_in_word.cmd == CMD_LN) begin
                            n_mb  = arg_au[OPW-1:0];
                            n_pw  = MAG_W'(arg_au);
                            n_mag = MAG_W'(arg_au);
                            n_neg = arg_u[63];
                            n_dvs = DVS_LN_INIT;
                        end else begin
                            n_mb  = OPW'(arg_ax);
                            n_pw  = MAG_W'(arg_ax);
                            n_mag = MAG_W'(arg_ax);
                            n_neg = i_in_word.arg_value[31];
                            n_dvs = (i_in_word.cmd == CMD_SIN) ? DVS_SIN_INIT
                                                               : DVS_ATAN_INIT;
                        end
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // A zero term means the sum no longer changes.
                if (r_mag == '0) begin
                    n_status = ST_CONV;
                    n_state  = S_OUT;
                end else if (r_used >= r_limit) begin
                    n_status = ST_LIMIT;
                    n_state  = S_OUT;
                end else begin
                    n_sum   = sum_sat;
                    n_used  = r_used + 8'd1;
                    n_mop   = (r_cmd == CMD_SIN) ? r_mag : r_pw;
                    n_pass  = 1'b0;
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                n_prod  = PROD_W'(mul_p);
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_prod  = r_prod + (PROD_W'(mul_p) << HALF_W);
                n_state = S_MUL_SAT;
            end
            S_MUL_SAT: begin
                // Sine and arctangent multiply by |x| twice, ln once.
                if (r_cmd != CMD_LN && !r_pass) begin
                    n_mop   = sat_res;
                    n_pass  = 1'b1;
                    n_state = S_MUL_LO;
                end else begin
                    n_pw        = sat_res;
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_mag = div_q;
                    // The ln series of x above 1 alternates; below 1 every
                    // term is negative.
                    n_neg = (r_cmd == CMD_LN && r_uneg) ? r_neg : !r_neg;
                    // Sine divisors follow k: (2k)(2k+1) grows by 8k + 6; arctangent steps by 2, ln by 1.
                    if (r_cmd == CMD_SIN) begin
                        n_dvs = r_dvs + DVS_W'({r_used, 3'b000}) + DVS_SIN_BIAS;
                    end else if (r_cmd == CMD_ATAN) begin
                        n_dvs = r_dvs + DVS_ATAN_STEP;
                    end else begin
                        n_dvs = r_dvs + DVS_LN_STEP;
                    end
                    n_state = S_CHECK;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_word.series_sum = sum_out;
                    n_out_word.terms_used = r_used;
                    n_out_word.status     = r_status;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_limit     <= TERM_LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_div_start <= n_div_start;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_mb       <= n_mb;
        r_mop      <= n_mop;
        r_prod     <= n_prod;
        r_pw       <= n_pw;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_uneg     <= n_uneg;
        r_pass     <= n_pass;
        r_sum      <= n_sum;
        r_used     <= n_used;
        r_status   <= n_status;
        r_dvs      <= n_dvs;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // An argument outside the domain yields an empty result.
    `SSAL_ASSERT_IMPLIES(a_domain_empty,
        o_out_valid && o_out_word.status == ST_DOMAIN,
        o_out_word.terms_used == 8'd0 && o_out_word.series_sum == 40'sd0,
        "domain word not empty")

    // Hitting the term cap means exactly term_limit terms were added.
    `SSAL_ASSERT_IMPLIES(a_limit_count,
        o_out_valid && o_out_word.status == ST_LIMIT,
        o_out_word.terms_used == r_limit,
        "term count differs from limit")

    // A division always belongs to a term already added.
    `SSAL_ASSERT_IMPLIES(a_div_has_term,
        r_state == S_DIV,
        r_used != 8'd0,
        "division without a term")

    // An accepted word always starts the sequencer.
    `SSAL_ASSERT_NEXT(a_accept_leaves_idle,
        i_in_valid && !o_in_stall,
        r_state == S_CHECK || r_state == S_OUT,
        "accepted word did not start")

endmodule

/* hdl/ssal_div.sv */
// ---------------------------------------------------------------------------
// Series evaluation unit: serial divider
// Unsigned restoring division, two quotient bits per clock cycle.
// ---------------------------------------------------------------------------
module ssal_div
    import ssal_pkg::*;
#(
    parameter int unsigned DVD_W = 62,
    parameter int unsigned DIV_W = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int unsigned ITERS = (DVD_W + 1) / 2;
    localparam int unsigned PAD_W = 2 * ITERS;
    localparam int unsigned CNT_W = $clog2(ITERS + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [PAD_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_dvs, n_dvs;

    always_comb begin
        logic [DIV_W:0]   sh1, sh2;
        logic [DIV_W-1:0] rem1;
        logic             ge1, ge2;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        // First step of the pair.
        sh1  = {r_rem, r_quo[PAD_W-1]};
        ge1  = sh1 >= {1'b0, r_dvs};
        rem1 = ge1 ? DIV_W'(sh1 - {1'b0, r_dvs}) : sh1[DIV_W-1:0];
        // Second step of the pair.
        sh2  = {rem1, r_quo[PAD_W-2]};
        ge2  = sh2 >= {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ITERS);
            n_rem  = '0;
            n_quo  = PAD_W'(i_dividend);
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge2 ? DIV_W'(sh2 - {1'b0, r_dvs}) : sh2[DIV_W-1:0];
            n_quo = {r_quo[PAD_W-3:0], ge1, ge2};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[DVD_W-1:0];

endmodule
